>>> design/rclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclp_pkg
// Types, character codes and command forms of the robot command line parser.
// ----------------------------------------------------------------------------
package rclp_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int POS_W  = 4;

    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
    localparam logic [BYTE_W-1:0] CH_V    = 8'h56;
    localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
    localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

    localparam logic KIND_SPEED    = 1'b0;
    localparam logic KIND_STATIONS = 1'b1;

    typedef enum logic [1:0] {
        FORM_SPEED = 2'd0,
        FORM_DASH  = 2'd1,
        FORM_ANY   = 2'd2
    } t_form;

    typedef enum logic [1:0] {
        TOK_CHAR = 2'd0,
        TOK_NUM  = 2'd1,
        TOK_ANY  = 2'd2
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind         kind;
        logic [BYTE_W-1:0] ch;
    } t_token;

    function automatic logic [POS_W-1:0] form_len(t_form f);
        logic [POS_W-1:0] len;
        case (f)
            FORM_SPEED: len = 4'd4;
            default:    len = 4'd7;
        endcase
        return len;
    endfunction

    function automatic t_token form_token(t_form f, logic [POS_W-1:0] p);
        t_token tok;
        tok = '{kind: TOK_CHAR, ch: 8'h00};
        case (p)
            4'd0: tok = '{kind: TOK_CHAR, ch: CH_R};
            4'd1: tok = '{kind: TOK_NUM,  ch: 8'h00};
            4'd2: tok = '{kind: TOK_CHAR, ch: (f == FORM_SPEED) ? CH_V : CH_P};
            4'd3: tok = '{kind: TOK_NUM,  ch: 8'h00};
            4'd4: begin
                if (f == FORM_DASH) begin
                    tok = '{kind: TOK_CHAR, ch: CH_DASH};
                end else if (f == FORM_ANY) begin
                    tok = '{kind: TOK_ANY, ch: 8'h00};
                end
            end
            4'd5: tok = '{kind: TOK_CHAR, ch: CH_P};
            4'd6: tok = '{kind: TOK_NUM,  ch: 8'h00};
            default: tok = '{kind: TOK_CHAR, ch: 8'h00};
        endcase
        return tok;
    endfunction

endpackage

>>> design/rclp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclp_ifs
// Valid/ready channels: received bytes in, decoded commands out.
// ----------------------------------------------------------------------------
interface rclp_rx_if import rclp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rclp_cmd_if import rclp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command_kind;
    logic [IDX_W-1:0] robot_index;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;

    modport source (output valid, output command_kind, output robot_index,
                    output first_value, output second_value, input ready);
    modport sink   (input valid, input command_kind, input robot_index,
                    input first_value, input second_value, output ready);
endinterface

>>> design/robot_command_line_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_command_line_parser_core
// Byte-stream parser for robot speed and station commands.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, unless a command waits on a stalled
// output, and emits at most one command per line, when CR or LF closes a
// non-empty line. A byte's transfer reaches the result register through the
// input register, then the matcher update, which is combinational and whose
// longest path is the multiply-by-ten and saturate of a number. Three form
// matchers (speed, dash-separated stations, any-separated stations) run side
// by side; the form is picked at line end from whether V or a dash was seen.
// Lines longer than LINE_CAPACITY-1 bytes restart empty; numbers saturate at
// 2^NUMBER_WIDTH-1; commands for robots at or above ROBOT_COUNT are dropped.
module robot_command_line_parser_core
    import rclp_pkg::*;
#(
    parameter int LINE_CAPACITY = 64,
    parameter int ROBOT_COUNT   = 16,
    parameter int NUMBER_WIDTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rclp_rx_if.sink            i_rx,
    rclp_cmd_if.source         o_cmd
);

    localparam int NW    = NUMBER_WIDTH;
    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int CMP_W = NUMBER_WIDTH + 1;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [CMP_W-1:0] ROBOT_LIM = CMP_W'(ROBOT_COUNT);

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             failed;
        logic             digit_seen;
        logic [NW-1:0]    robot;
        logic [NW-1:0]    first;
        logic [NW-1:0]    second;
    } t_matcher;

    function automatic t_matcher feed(t_form f, t_matcher m, logic [BYTE_W-1:0] c);
        t_matcher         r;
        t_token           tok;
        logic [POS_W-1:0] len;
        logic             is_digit;
        logic             do_match;
        logic [NW-1:0]    slot;
        logic [NW+3:0]    prod;
        logic [NW-1:0]    sat;
        r        = m;
        len      = form_len(f);
        tok      = form_token(f, m.pos);
        is_digit = (c >= CH_0) && (c <= CH_9);
        do_match = 1'b0;
        case (m.pos)
            4'd1:    slot = m.robot;
            4'd3:    slot = m.first;
            default: slot = m.second;
        endcase
        // slot*10 + digit, never beyond NW+4 bits
        prod = (NW+4)'({slot, 3'b000}) + (NW+4)'({slot, 1'b0}) + (NW+4)'(c[3:0]);
        sat  = (prod[NW+3:NW] != 4'd0) ? {NW{1'b1}} : prod[NW-1:0];
        if (!m.failed && (m.pos < len)) begin
            if (tok.kind == TOK_NUM) begin
                if (is_digit) begin
                    case (m.pos)
                        4'd1:    r.robot  = sat;
                        4'd3:    r.first  = sat;
                        default: r.second = sat;
                    endcase
                    r.digit_seen = 1'b1;
                end else if (!m.digit_seen) begin
                    r.failed = 1'b1;
                end else begin
                    // number closed: this byte is judged against the next token
                    r.digit_seen = 1'b0;
                    r.pos        = m.pos + 4'd1;
                    if (r.pos < len) begin
                        tok      = form_token(f, r.pos);
                        do_match = 1'b1;
                    end
                end
            end else begin
                do_match = 1'b1;
            end
            if (do_match) begin
                if (tok.kind == TOK_ANY || (tok.kind == TOK_CHAR && tok.ch == c)) begin
                    r.pos = r.pos + 4'd1;
                end else begin
                    r.failed = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic form_ok(t_form f, t_matcher m);
        logic [POS_W-1:0] len;
        len = form_len(f);
        return !m.failed && ((m.pos >= len) || ((m.pos == len - 4'd1) && m.digit_seen));
    endfunction

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // line state
    logic [LEN_W-1:0]  r_line_len,  n_line_len;
    logic              r_saw_speed, n_saw_speed;
    logic              r_saw_dash,  n_saw_dash;
    t_matcher          r_m [3];
    t_matcher          n_m [3];

    // result register
    logic              r_out_valid;
    logic              r_out_kind,   n_out_kind;
    logic [IDX_W-1:0]  r_out_robot,  n_out_robot;
    logic [VAL_W-1:0]  r_out_first,  n_out_first;
    logic [VAL_W-1:0]  r_out_second, n_out_second;
    logic              n_result;

    logic              w_proc;
    logic              w_eol;
    t_form             w_form;
    t_matcher          w_sel;

    assign w_proc     = r_in_valid && (!r_out_valid || o_cmd.ready);
    assign i_rx.ready = !r_in_valid || w_proc;
    assign w_eol      = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    assign w_form     = r_saw_speed ? FORM_SPEED : (r_saw_dash ? FORM_DASH : FORM_ANY);
    assign w_sel      = r_m[w_form];

    always_comb begin
        n_line_len   = r_line_len;
        n_saw_speed  = r_saw_speed;
        n_saw_dash   = r_saw_dash;
        n_m          = r_m;
        n_result     = 1'b0;
        n_out_kind   = (w_form == FORM_SPEED) ? KIND_SPEED : KIND_STATIONS;
        n_out_robot  = w_sel.robot[IDX_W-1:0];
        n_out_first  = VAL_W'(w_sel.first);
        n_out_second = (w_form == FORM_SPEED) ? '0 : VAL_W'(w_sel.second);
        if (w_eol) begin
            if (r_line_len != '0) begin
                n_result    = form_ok(w_form, w_sel) && ({1'b0, w_sel.robot} < ROBOT_LIM);
                n_line_len  = '0;
                n_saw_speed = 1'b0;
                n_saw_dash  = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    n_m[i] = '0;
                end
            end
        end else if (r_line_len < LEN_MAX) begin
            n_line_len = r_line_len + 1'b1;
            if (r_in_byte == CH_V) begin
                n_saw_speed = 1'b1;
            end
            if (r_in_byte == CH_DASH) begin
                n_saw_dash = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                n_m[i] = feed(t_form'(2'(i)), r_m[i], r_in_byte);
            end
        end else begin
            // overlong line: drop this byte and start afresh
            n_line_len  = '0;
            n_saw_speed = 1'b0;
            n_saw_dash  = 1'b0;
            for (int i = 0; i < 3; i++) begin
                n_m[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line_len  <= '0;
            r_saw_speed <= 1'b0;
            r_saw_dash  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= '0;
            end
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_proc) begin
                r_out_valid <= n_result;
                r_line_len  <= n_line_len;
                r_saw_speed <= n_saw_speed;
                r_saw_dash  <= n_saw_dash;
                r_m         <= n_m;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_proc && n_result) begin
            r_out_kind   <= n_out_kind;
            r_out_robot  <= n_out_robot;
            r_out_first  <= n_out_first;
            r_out_second <= n_out_second;
        end
    end

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.command_kind = r_out_kind;
    assign o_cmd.robot_index  = r_out_robot;
    assign o_cmd.first_value  = r_out_first;
    assign o_cmd.second_value = r_out_second;

`ifndef SYNTHESIS
    a_result_from_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc && w_eol))
        else $error("result raised without a line end");

    a_eol_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_eol) |=> (r_line_len == '0) && !r_saw_speed && !r_saw_dash)
        else $error("line state not cleared at line end");

    a_speed_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_SPEED) |-> (r_out_second == '0))
        else $error("speed command with non-zero second value");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> tb/robot_command_line_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_command_line_parser_core_test
// Self-checking bench for the robot command line parser.
// ----------------------------------------------------------------------------
// Streams text lines into the parser: a directed set covering each command
// form, the number, robot and line length limits and the malformed cases,
// then random lines. Most random lines are well formed with random content;
// the rest are corrupted, noise or overlong. A line predictor tracks all three
// forms per byte and queues the expected command; each command transfer is
// checked field by field. Both handshakes idle at random.
module robot_command_line_parser_core_test
    import rclp_pkg::*;
();

    localparam int ROBOT_LIMIT   = 16;
    localparam int LINE_HOLD_MAX = 63;
    localparam longint unsigned NUMBER_MAX = 65535;
    localparam int SPEED_TOKENS   = 4;
    localparam int STATION_TOKENS = 7;
    localparam int RANDOM_BYTES  = 1700;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] TOP_BYTE  = 8'hFF;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] robot;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
    } t_command;

    class command_scoreboard;
        t_command    expected_q[$];
        int unsigned n_checked;
        int unsigned n_errors;
        int unsigned n_reported;

        // per-line state; one matcher per command form
        int unsigned     line_len;
        bit              saw_speed;
        bit              saw_dash;
        int              pos[3];
        bit              failed[3];
        bit              digit_seen[3];
        int              nums_done[3];
        longint unsigned value[3][3];

        function new();
            clear_line();
        endfunction

        function void clear_line();
            line_len  = 0;
            saw_speed = 1'b0;
            saw_dash  = 1'b0;
            for (int f = 0; f < 3; f++) begin
                pos[f]        = 0;
                failed[f]     = 1'b0;
                digit_seen[f] = 1'b0;
                nums_done[f]  = 0;
                for (int k = 0; k < 3; k++) value[f][k] = 0;
            end
        endfunction

        function int form_length(t_form f);
            return (f == FORM_SPEED) ? SPEED_TOKENS : STATION_TOKENS;
        endfunction

        function t_tok_kind token_of(t_form f, int p, output logic [7:0] ch);
            ch = CH_P;
            case (p)
                0: begin
                    ch = CH_R;
                    return TOK_CHAR;
                end
                1, 3, 6: return TOK_NUM;
                2: begin
                    ch = (f == FORM_SPEED) ? CH_V : CH_P;
                    return TOK_CHAR;
                end
                4: begin
                    if (f == FORM_DASH) begin
                        ch = CH_DASH;
                        return TOK_CHAR;
                    end
                    return TOK_ANY;
                end
                default: return TOK_CHAR;
            endcase
        endfunction

        function void feed_form(t_form f, logic [7:0] c);
            int              len;
            t_tok_kind       k;
            logic [7:0]      ch;
            longint unsigned v;
            len = form_length(f);
            if (failed[f] || pos[f] >= len) return;
            k = token_of(f, pos[f], ch);
            if (k == TOK_NUM) begin
                if (c >= CH_0 && c <= CH_9) begin
                    v = value[f][nums_done[f]] * 10 + longint'(c - CH_0);
                    if (v > NUMBER_MAX) v = NUMBER_MAX;
                    value[f][nums_done[f]] = v;
                    digit_seen[f] = 1'b1;
                    return;
                end
                if (!digit_seen[f]) begin
                    failed[f] = 1'b1;
                    return;
                end
                // number closed by a non-digit, which then meets the next token
                digit_seen[f] = 1'b0;
                nums_done[f]++;
                pos[f]++;
                if (pos[f] >= len) return;
                k = token_of(f, pos[f], ch);
            end
            if (k == TOK_ANY || ch == c) pos[f]++;
            else failed[f] = 1'b1;
        endfunction

        function bit form_complete(t_form f);
            int len;
            len = form_length(f);
            if (failed[f]) return 1'b0;
            if (pos[f] >= len) return 1'b1;
            return (pos[f] == len - 1) && digit_seen[f];
        endfunction

        function void note_byte(logic [7:0] c);
            t_form    f;
            t_command cmd;
            if (c == CH_CR || c == CH_LF) begin
                if (line_len > 0) begin
                    f = saw_speed ? FORM_SPEED : (saw_dash ? FORM_DASH : FORM_ANY);
                    if (form_complete(f) && value[f][0] < ROBOT_LIMIT) begin
                        cmd.kind         = (f == FORM_SPEED) ? KIND_SPEED : KIND_STATIONS;
                        cmd.robot        = value[f][0][IDX_W-1:0];
                        cmd.first_value  = value[f][1][VAL_W-1:0];
                        cmd.second_value = (f == FORM_SPEED) ? '0 : value[f][2][VAL_W-1:0];
                        expected_q.push_back(cmd);
                    end
                    clear_line();
                end
            end else if (line_len < LINE_HOLD_MAX) begin
                line_len++;
                if (c == CH_V) saw_speed = 1'b1;
                if (c == CH_DASH) saw_dash = 1'b1;
                feed_form(FORM_SPEED, c);
                feed_form(FORM_DASH, c);
                feed_form(FORM_ANY, c);
            end else begin
                // overlong: byte dropped, line restarts empty
                clear_line();
            end
        endfunction

        function void check_command(t_command got);
            t_command want;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_reported < REPORT_LIMIT) begin
                    n_reported++;
                    $display("%0t: unexpected command: kind %0d robot %0d values %0d %0d",
                             $realtime, got.kind, got.robot, got.first_value,
                             got.second_value);
                end
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.kind !== want.kind || got.robot !== want.robot ||
                got.first_value !== want.first_value ||
                got.second_value !== want.second_value) begin
                n_errors++;
                if (n_reported < REPORT_LIMIT) begin
                    n_reported++;
                    $display("%0t: command mismatch: expected kind %0d robot %0d values %0d %0d",
                             $realtime, want.kind, want.robot, want.first_value,
                             want.second_value);
                    $display("%0t:                   got      kind %0d robot %0d values %0d %0d",
                             $realtime, got.kind, got.robot, got.first_value,
                             got.second_value);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rclp_rx_if  rx_ch();
    rclp_cmd_if cmd_ch();

    robot_command_line_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch.sink),
        .o_cmd   (cmd_ch.source)
    );

    command_scoreboard sb = new();

    logic [7:0] tx_bytes[$];
    logic [7:0] line_q[$];
    int unsigned n_lines;
    int burst_left[2];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---- stimulus building ----
    function void push_text(string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endfunction

    function void push_num(longint unsigned v);
        push_text($sformatf("%0d", v));
    endfunction

    function void push_digits(int n);
        repeat (n) line_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    function void commit_line();
        foreach (line_q[i]) tx_bytes.push_back(line_q[i]);
        line_q.delete();
        n_lines++;
    endfunction

    function void add_line(string s);
        push_text(s);
        commit_line();
    endfunction

    function void push_robot();
        if ($urandom_range(0, 3) != 0) push_num($urandom_range(0, ROBOT_LIMIT - 1));
        else push_digits($urandom_range(1, 6));
    endfunction

    function void push_terminator();
        case ($urandom_range(0, 2))
            0: line_q.push_back(CH_CR);
            1: line_q.push_back(CH_LF);
            default: begin
                line_q.push_back(CH_CR);
                line_q.push_back(CH_LF);
            end
        endcase
    endfunction

    function void build_directed();
        add_line("R3V120\n");
        add_line("R15P7-P9\r");
        add_line("R0P1xP2\n");
        add_line("R0V0\r\n");
        add_line("R2V65535\n");
        add_line("R2V9999999\n");
        add_line("R1P65536-P70000\n");
        add_line("R16V5\n");
        add_line("R99999P1-P2\n");
        add_line("\n\r");
        add_line("R4V5abc\n");
        add_line("R7P8-P9 end\n");
        add_line("R1P2-P3V\n");
        add_line("R1P2-P\n");
        add_line("RV5\n");
        add_line("R 1V2\n");
        add_line("R1V+2\n");
        add_line("R1P2--P3\n");
        add_line("R8P1VP2\n");
        add_line("r1v2\n");
        // zero byte and top byte as station separators
        push_text("R9P4");
        line_q.push_back(NUL_BYTE);
        add_line("P6\n");
        push_text("R10P4");
        line_q.push_back(TOP_BYTE);
        add_line("P6\r");
        // line held at full capacity, then one that overflows and eats the next R
        push_text("R2V3");
        repeat (LINE_HOLD_MAX - 4) push_text("x");
        add_line("\r");
        push_text("R5V7");
        repeat (LINE_HOLD_MAX - 4) push_text("x");
        add_line("R6V8\n");
    endfunction

    function void build_random_line();
        int mode;
        int form_sel;
        int at;
        int target;
        mode = $urandom_range(0, 99);
        if (mode < 85) begin
            form_sel = $urandom_range(0, 2);
            line_q.push_back(CH_R);
            push_robot();
            if (form_sel == 0) begin
                line_q.push_back(CH_V);
                push_digits($urandom_range(1, 6));
            end else begin
                line_q.push_back(CH_P);
                push_digits($urandom_range(1, 6));
                if (form_sel == 1) line_q.push_back(CH_DASH);
                else line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(CH_P);
                push_digits($urandom_range(1, 6));
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom_range(0, 255)));
            end
            // corrupted variant: one byte replaced or lost
            if (mode >= 70) begin
                at = $urandom_range(0, line_q.size() - 1);
                if ($urandom_range(0, 1) == 0) line_q[at] = 8'($urandom_range(0, 255));
                else line_q.delete(at);
            end
        end else if (mode < 95) begin
            repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            target = $urandom_range(LINE_HOLD_MAX - 5, LINE_HOLD_MAX + 7);
            line_q.push_back(CH_R);
            push_robot();
            line_q.push_back(CH_V);
            push_digits($urandom_range(1, 5));
            while (line_q.size() < target)
                line_q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
        end
        push_terminator();
        commit_line();
    endfunction

    // ---- handshake driving ----
    function int draw_gap(int side);
        if (burst_left[side] > 0) begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst_left[side] = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task send_byte(logic [7:0] b);
        int gap;
        gap = draw_gap(0);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
        @(negedge i_clk);
    endtask

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(1);
            if (gap > 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
            @(negedge i_clk);
        end
    end

    // transfers seen at the rising edge, before the block's registers move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.rx_byte);
            if (cmd_ch.valid && cmd_ch.ready) begin
                sb.check_command('{kind: cmd_ch.command_kind, robot: cmd_ch.robot_index,
                                   first_value: cmd_ch.first_value,
                                   second_value: cmd_ch.second_value});
            end
        end
    end

    initial begin
        int n_directed;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cmd_ch.ready  <= 1'b0;
        i_rst_n       <= 1'b0;
        build_directed();
        n_directed = tx_bytes.size();
        while (tx_bytes.size() < n_directed + RANDOM_BYTES) build_random_line();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
        rx_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.n_errors += sb.expected_q.size();

        $display("Sent %0d bytes over %0d lines (%0d directed bytes); %0d commands compared.",
                 tx_bytes.size(), n_lines, n_directed, sb.n_checked);
        $display("Failures: %0d.", sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
